// ===== src/urc_pkg.sv =====
`timescale 1ns / 1ps
// urc_pkg: shared types, field widths and status codes for the udp receive checker
// used by urc_port_table and udp_receive_checker_core; no dependencies
package urc_pkg;

    localparam int DATA_W    = 8;
    localparam int IP_W      = 32;
    localparam int PORT_W    = 16;
    localparam int SINK_W    = 3;
    localparam int CNT_W     = 17;
    localparam int SUM_W     = 16;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 3;

    localparam logic [CNT_W-1:0] CNT_MAX   = '1;
    localparam logic [CNT_W-1:0] HDR_BYTES = 17'd8;
    localparam logic [SUM_W-1:0] UDP_PROTO = 16'd17;

    typedef enum logic [1:0] {
        ACT_BYTE  = 2'd0,
        ACT_OPEN  = 2'd1,
        ACT_CLOSE = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_DELIVERED = 3'd0,
        ST_LEN_ERR   = 3'd1,
        ST_CKS_ERR   = 3'd2,
        ST_UNREACH   = 3'd3,
        ST_OPENED    = 3'd4,
        ST_CLOSED    = 3'd5,
        ST_FULL      = 3'd6
    } t_status;

    typedef struct packed {
        logic              en;
        logic              open;
        logic [PORT_W-1:0] port;
        logic [SINK_W-1:0] sink;
    } t_tbl_edit;

    typedef struct packed {
        logic              hit;
        logic [SINK_W-1:0] sink;
    } t_tbl_hit;

    // end-around carry fold of a 17-bit sum whose value is at most 0x1fffe
    function automatic logic [SUM_W-1:0] oc_fold17(input logic [SUM_W:0] s);
        logic [SUM_W:0] t;
        t = {1'b0, s[SUM_W-1:0]} + {{SUM_W{1'b0}}, s[SUM_W]};
        return t[SUM_W-1:0];
    endfunction

endpackage

// ===== src/urc_port_table.sv =====
`timescale 1ns / 1ps
// urc_port_table: table of open udp ports with their bound handler ids
// parallel match on every entry; depends on urc_pkg
module urc_port_table #(
    parameter int ENTRIES = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  urc_pkg::t_tbl_edit      i_edit,
    input  logic [urc_pkg::PORT_W-1:0] i_lookup_port,
    output urc_pkg::t_tbl_hit       o_lookup,
    output logic                    o_full
);
    import urc_pkg::*;

    localparam logic [ENTRIES-1:0] ONE = ENTRIES'(1);

    logic [ENTRIES-1:0] r_valid;
    logic [PORT_W-1:0]  r_port [ENTRIES];
    logic [SINK_W-1:0]  r_sink [ENTRIES];

    logic [ENTRIES-1:0] w_edit_match;
    logic [ENTRIES-1:0] w_look_match;
    logic [ENTRIES-1:0] w_free;
    logic [ENTRIES-1:0] w_first_free;
    logic [ENTRIES-1:0] w_target;
    logic [ENTRIES-1:0] n_valid;
    logic [SINK_W-1:0]  w_sink;
    logic               w_do_open;

    always_comb begin
        w_sink = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_edit_match[i] = r_valid[i] && (r_port[i] == i_edit.port);
            w_look_match[i] = r_valid[i] && (r_port[i] == i_lookup_port);
            if (w_look_match[i]) begin
                w_sink = w_sink | r_sink[i];
            end
        end
    end

    // lowest free entry as a one-hot vector
    assign w_free       = ~r_valid;
    assign w_first_free = w_free & (~w_free + ONE);
    assign w_target     = (|w_edit_match) ? w_edit_match : w_first_free;
    assign o_full       = !(|w_edit_match) && !(|w_free);
    assign w_do_open    = i_edit.en && i_edit.open && !o_full;

    assign o_lookup.hit  = |w_look_match;
    assign o_lookup.sink = w_sink;

    always_comb begin
        n_valid = r_valid;
        if (w_do_open) begin
            n_valid = r_valid | w_target;
        end else if (i_edit.en && !i_edit.open) begin
            n_valid = r_valid & ~w_edit_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_do_open && w_target[i]) begin
                r_port[i] <= i_edit.port;
                r_sink[i] <= i_edit.sink;
            end
        end
    end

endmodule

// ===== src/udp_receive_checker_core.sv =====
`timescale 1ns / 1ps
// udp_receive_checker_core: per-byte udp header capture, checksum, port demux verdict and port table edits
// path: an accepted word waits in the input register; its result is then registered in the result register
// throughput: one word per cycle unless a held result stalls; header, checksum and port match are one pass of logic
// reset: synchronous active low; clears the valid bits of both pipeline registers, the byte count,
// the port table valid bits and local_ip (zero)
module udp_receive_checker_core #(
    parameter int TABLE_ENTRIES = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config: local_ip
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [urc_pkg::IP_W-1:0]         i_cfg_data,
    // input stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [urc_pkg::S_TDATA_W-1:0]    i_s_tdata,  // data[7:0] src_ip[39:8] port[55:40] sink_id[58:56]
    input  logic                             i_s_tlast,
    input  logic [urc_pkg::S_TUSER_W-1:0]    i_s_tuser,  // action[1:0]
    // result stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [urc_pkg::M_TDATA_W-1:0]    o_m_tdata,  // from_port[15:0] to_port[31:16] payload_len[47:32] sink_id_out[50:48]
    output logic [urc_pkg::M_TUSER_W-1:0]    o_m_tuser   // status[2:0]
);
    import urc_pkg::*;

    localparam logic [2:0] HP_SRC_HI = 3'd0;
    localparam logic [2:0] HP_SRC_LO = 3'd1;
    localparam logic [2:0] HP_DST_HI = 3'd2;
    localparam logic [2:0] HP_DST_LO = 3'd3;
    localparam logic [2:0] HP_LEN_HI = 3'd4;
    localparam logic [2:0] HP_LEN_LO = 3'd5;
    localparam logic [2:0] HP_CKS_HI = 3'd6;
    localparam logic [2:0] HP_CKS_LO = 3'd7;

    // configuration: local ip kept only as its folded pseudo-header share with the protocol
    logic [SUM_W-1:0] r_local_sum;
    logic [SUM_W+1:0] w_cfg_wide;
    logic [SUM_W:0]   w_cfg_f1;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wide  = {2'b0, i_cfg_data[31:16]} + {2'b0, i_cfg_data[15:0]} + {2'b0, UDP_PROTO};
    assign w_cfg_f1    = {1'b0, w_cfg_wide[SUM_W-1:0]} + {15'b0, w_cfg_wide[SUM_W+1:SUM_W]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_sum <= UDP_PROTO;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_local_sum <= oc_fold17(w_cfg_f1);
        end
    end

    // input register
    logic              r_in_valid;
    t_action           r_act;
    logic [DATA_W-1:0] r_data;
    logic              r_last;
    logic [IP_W-1:0]   r_src_ip;
    logic [PORT_W-1:0] r_port;
    logic [SINK_W-1:0] r_sink;

    // result register
    logic              r_out_valid;
    t_status           r_status;
    logic [PORT_W-1:0] r_from_port;
    logic [PORT_W-1:0] r_to_port;
    logic [PORT_W-1:0] r_plen;
    logic [SINK_W-1:0] r_sink_out;

    // datagram state
    logic [CNT_W-1:0]  r_byte_count;
    logic [SUM_W-1:0]  r_sum_acc;
    logic [SUM_W-1:0]  r_peer_sum;
    logic [DATA_W-1:0] r_held;
    logic [PORT_W-1:0] r_hdr_src;
    logic [PORT_W-1:0] r_hdr_dst;
    logic [PORT_W-1:0] r_hdr_len;
    logic [PORT_W-1:0] r_rx_cks;

    logic w_is_byte, w_is_open, w_is_close;
    logic w_has_result, w_advance, w_s_accept, w_byte_go;

    assign w_is_byte    = (r_act == ACT_BYTE);
    assign w_is_open    = (r_act == ACT_OPEN);
    assign w_is_close   = (r_act == ACT_CLOSE);
    assign w_has_result = w_is_open || w_is_close || (w_is_byte && r_last);
    assign w_advance    = r_in_valid && (!w_has_result || !r_out_valid || i_m_tready);
    assign o_s_tready   = !r_in_valid || w_advance;
    assign w_s_accept   = i_s_tvalid && o_s_tready;
    assign w_byte_go    = w_advance && w_is_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_act    <= t_action'(i_s_tuser);
            r_data   <= i_s_tdata[7:0];
            r_last   <= i_s_tlast;
            r_src_ip <= i_s_tdata[39:8];
            r_port   <= i_s_tdata[55:40];
            r_sink   <= i_s_tdata[58:56];
        end
    end

    // per-byte header capture and running sum
    logic              w_first;
    logic              w_in_hdr;
    logic [CNT_W-1:0]  w_cnt_inc;
    logic [CNT_W-1:0]  n_byte_count;
    logic [PORT_W-1:0] n_hdr_src, n_hdr_dst, n_hdr_len, n_rx_cks;
    logic [SUM_W-1:0]  w_word;
    logic [SUM_W-1:0]  w_base_sum;
    logic [SUM_W-1:0]  n_sum_acc;
    logic [SUM_W-1:0]  n_peer_sum;
    logic [DATA_W-1:0] n_held;

    assign w_first   = (r_byte_count == '0);
    assign w_in_hdr  = (r_byte_count[CNT_W-1:3] == '0);
    assign w_cnt_inc = (r_byte_count == CNT_MAX) ? r_byte_count : r_byte_count + 17'd1;
    assign n_byte_count = r_last ? '0 : w_cnt_inc;

    always_comb begin
        n_hdr_src = w_first ? '0 : r_hdr_src;
        n_hdr_dst = w_first ? '0 : r_hdr_dst;
        n_hdr_len = w_first ? '0 : r_hdr_len;
        n_rx_cks  = w_first ? '0 : r_rx_cks;
        if (w_in_hdr) begin
            unique case (r_byte_count[2:0])
                HP_SRC_HI: n_hdr_src[15:8] = r_data;
                HP_SRC_LO: n_hdr_src[7:0]  = r_data;
                HP_DST_HI: n_hdr_dst[15:8] = r_data;
                HP_DST_LO: n_hdr_dst[7:0]  = r_data;
                HP_LEN_HI: n_hdr_len[15:8] = r_data;
                HP_LEN_LO: n_hdr_len[7:0]  = r_data;
                HP_CKS_HI: n_rx_cks[15:8]  = r_data;
                HP_CKS_LO: n_rx_cks[7:0]   = r_data;
                default:   n_hdr_src       = n_hdr_src;
            endcase
        end
    end

    // checksum field bytes count as zero; an odd final byte is padded
    always_comb begin
        w_word = '0;
        if (r_byte_count[0]) begin
            if (!(w_in_hdr && r_byte_count[2:0] == HP_CKS_LO)) begin
                w_word = {r_held, r_data};
            end
        end else if (r_last && !(w_in_hdr && r_byte_count[2:0] == HP_CKS_HI)) begin
            w_word = {r_data, 8'h00};
        end
    end

    logic [SUM_W:0] w_acc_raw, w_peer_raw;

    assign w_base_sum = w_first ? '0 : r_sum_acc;
    assign w_acc_raw  = {1'b0, w_base_sum} + {1'b0, w_word};
    assign n_sum_acc  = oc_fold17(w_acc_raw);
    assign w_peer_raw = {1'b0, r_src_ip[31:16]} + {1'b0, r_src_ip[15:0]};
    assign n_peer_sum = w_first ? oc_fold17(w_peer_raw) : r_peer_sum;
    assign n_held     = r_byte_count[0] ? r_held : r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
        end else if (w_byte_go) begin
            r_byte_count <= n_byte_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_byte_go) begin
            r_sum_acc  <= n_sum_acc;
            r_peer_sum <= n_peer_sum;
            r_held     <= n_held;
            r_hdr_src  <= n_hdr_src;
            r_hdr_dst  <= n_hdr_dst;
            r_hdr_len  <= n_hdr_len;
            r_rx_cks   <= n_rx_cks;
        end
    end

    // final verdict: the order of one's complement additions does not change the result
    logic [SUM_W+2:0] w_fin_wide;
    logic [SUM_W:0]   w_fin_f1;
    logic [SUM_W-1:0] w_fin_sum;
    logic [SUM_W-1:0] w_expect;
    logic             w_len_err;
    logic             w_cks_err;

    assign w_fin_wide = {3'b0, w_base_sum} + {3'b0, w_word} + {3'b0, r_local_sum}
                      + {3'b0, n_peer_sum} + {3'b0, w_cnt_inc[SUM_W-1:0]};
    assign w_fin_f1   = {1'b0, w_fin_wide[SUM_W-1:0]} + {14'b0, w_fin_wide[SUM_W+2:SUM_W]};
    assign w_fin_sum  = oc_fold17(w_fin_f1);
    assign w_expect   = (~w_fin_sum == '0) ? '1 : ~w_fin_sum;
    assign w_len_err  = (w_cnt_inc < HDR_BYTES) || (w_cnt_inc < {1'b0, n_hdr_len})
                      || w_cnt_inc[CNT_W-1];
    assign w_cks_err  = (n_rx_cks != '0) && (n_rx_cks != w_expect);

    // port table
    t_tbl_edit w_edit;
    t_tbl_hit  w_hit;
    logic      w_full;

    assign w_edit.en   = w_advance && (w_is_open || w_is_close);
    assign w_edit.open = w_is_open;
    assign w_edit.port = r_port;
    assign w_edit.sink = r_sink;

    urc_port_table #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_port_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_edit        (w_edit),
        .i_lookup_port (n_hdr_dst),
        .o_lookup      (w_hit),
        .o_full        (w_full)
    );

    // result word
    t_status           n_status;
    logic [PORT_W-1:0] n_from_port, n_to_port, n_plen;
    logic [SINK_W-1:0] n_sink_out;
    logic [CNT_W-1:0]  w_plen_full;

    assign w_plen_full = w_cnt_inc - HDR_BYTES;

    always_comb begin
        n_from_port = '0;
        n_to_port   = r_port;
        n_plen      = '0;
        n_sink_out  = '0;
        if (w_is_open) begin
            n_status = w_full ? ST_FULL : ST_OPENED;
        end else if (w_is_close) begin
            n_status = ST_CLOSED;
        end else begin
            n_from_port = n_hdr_src;
            n_to_port   = n_hdr_dst;
            if (w_len_err) begin
                n_status = ST_LEN_ERR;
            end else begin
                n_plen = w_plen_full[PORT_W-1:0];
                if (w_cks_err) begin
                    n_status = ST_CKS_ERR;
                end else if (w_hit.hit) begin
                    n_status   = ST_DELIVERED;
                    n_sink_out = w_hit.sink;
                end else begin
                    n_status = ST_UNREACH;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_has_result) begin
            r_status    <= n_status;
            r_from_port <= n_from_port;
            r_to_port   <= n_to_port;
            r_plen      <= n_plen;
            r_sink_out  <= n_sink_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {5'b0, r_sink_out, r_plen, r_to_port, r_from_port};

`ifndef SYNTHESIS
    a_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_byte_go && r_last) |=> (r_byte_count == '0))
        else $error("byte count not cleared after last byte");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_byte_count != $past(r_byte_count)) |->
        ((r_byte_count == '0) || (r_byte_count == $past(r_byte_count) + 17'd1)))
        else $error("byte count moved by other than one");

    a_port_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_OPENED || r_status == ST_CLOSED
                         || r_status == ST_FULL))
        |-> (r_from_port == '0 && r_plen == '0 && r_sink_out == '0))
        else $error("port edit result carries datagram fields");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for udp_receive_checker_core, byte stream in, verdicts out
// depends on urc_pkg and the core; a scoreboard class predicts every verdict and table edit
module testbench;
    import urc_pkg::*;

    localparam int          N_SLOTS     = 8;
    localparam longint      CYCLE_LIMIT = 2000000;
    localparam logic [1:0]  ACT_IGNORED = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  data;
        logic        last;
        logic [31:0] src_ip;
        logic [15:0] port;
        logic [2:0]  sink;
    } rx_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] from_port;
        logic [15:0] to_port;
        logic [15:0] payload_len;
        logic [2:0]  sink;
    } verdict_t;

    typedef enum {DG_GOOD, DG_ZERO_CKS, DG_BAD_CKS, DG_LONG_FIELD, DG_SHORT} dg_kind_t;

    class udp_verdicts #(int SLOTS = 8);
        logic [31:0] local_ip;
        logic [16:0] nbytes;
        logic [15:0] acc;
        logic [7:0]  held;
        logic [31:0] peer;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] hlen;
        logic [15:0] rx_cks;
        logic        slot_used [SLOTS];
        logic [15:0] slot_port [SLOTS];
        logic [2:0]  slot_sink [SLOTS];
        verdict_t    pending [$];
        int          errors;
        int          datagrams;
        int          edits;
        int          tally [8];

        function new();
            local_ip  = '0;
            nbytes    = '0;
            acc       = '0;
            held      = '0;
            peer      = '0;
            sport     = '0;
            dport     = '0;
            hlen      = '0;
            rx_cks    = '0;
            errors    = 0;
            datagrams = 0;
            edits     = 0;
            foreach (slot_used[i]) begin
                slot_used[i] = 1'b0;
                slot_port[i] = '0;
                slot_sink[i] = '0;
            end
            foreach (tally[i]) tally[i] = 0;
        endfunction

        static function logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
            logic [16:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[15:0] + {15'd0, s[16]};
        endfunction

        function int find_slot(logic [15:0] p);
            for (int i = 0; i < SLOTS; i++)
                if (slot_used[i] && slot_port[i] == p) return i;
            return -1;
        endfunction

        // one accepted input word: update state, queue the verdict it causes
        function void take_word(rx_word_t w);
            verdict_t    v;
            int          slot;
            logic [16:0] pos;
            logic [16:0] count;
            logic [15:0] s;
            logic [15:0] want;
            v = '0;
            if (w.action == ACT_OPEN || w.action == ACT_CLOSE) begin
                edits++;
                slot = find_slot(w.port);
                v.to_port = w.port;
                if (w.action == ACT_CLOSE) begin
                    v.status = ST_CLOSED;
                    if (slot >= 0) slot_used[slot] = 1'b0;
                end else begin
                    // lowest free entry when the port is not bound yet
                    if (slot < 0)
                        for (int i = SLOTS - 1; i >= 0; i--)
                            if (!slot_used[i]) slot = i;
                    if (slot < 0) begin
                        v.status = ST_FULL;
                    end else begin
                        v.status        = ST_OPENED;
                        slot_used[slot] = 1'b1;
                        slot_port[slot] = w.port;
                        slot_sink[slot] = w.sink;
                    end
                end
                pending.push_back(v);
                return;
            end
            if (w.action != ACT_BYTE) return;

            pos = nbytes;
            if (pos == 0) begin
                peer   = w.src_ip;
                acc    = '0;
                held   = '0;
                sport  = '0;
                dport  = '0;
                hlen   = '0;
                rx_cks = '0;
            end
            case (pos)
                17'd0: sport[15:8]  = w.data;
                17'd1: sport[7:0]   = w.data;
                17'd2: dport[15:8]  = w.data;
                17'd3: dport[7:0]   = w.data;
                17'd4: hlen[15:8]   = w.data;
                17'd5: hlen[7:0]    = w.data;
                17'd6: rx_cks[15:8] = w.data;
                17'd7: rx_cks[7:0]  = w.data;
                default: ;
            endcase
            // checksum field counts as zero, odd tail byte padded low
            if (pos[0]) begin
                if (pos != 17'd7) acc = ones_add(acc, {held, w.data});
            end else begin
                held = w.data;
                if (w.last && pos != 17'd6) acc = ones_add(acc, {w.data, 8'h00});
            end
            if (nbytes != '1) nbytes = nbytes + 17'd1;
            if (!w.last) return;

            count  = nbytes;
            nbytes = '0;
            datagrams++;
            v.from_port = sport;
            v.to_port   = dport;
            if (count < 17'd8 || count < {1'b0, hlen} || count > 17'h0FFFF) begin
                v.status = ST_LEN_ERR;
            end else begin
                v.payload_len = count[15:0] - 16'd8;
                s    = ones_add(acc, peer[31:16]);
                s    = ones_add(s, peer[15:0]);
                s    = ones_add(s, local_ip[31:16]);
                s    = ones_add(s, local_ip[15:0]);
                s    = ones_add(s, UDP_PROTO);
                s    = ones_add(s, count[15:0]);
                want = ~s;
                if (want == 16'h0000) want = 16'hFFFF;
                slot = find_slot(dport);
                if (rx_cks != 16'h0000 && rx_cks != want) begin
                    v.status = ST_CKS_ERR;
                end else if (slot < 0) begin
                    v.status = ST_UNREACH;
                end else begin
                    v.status = ST_DELIVERED;
                    v.sink   = slot_sink[slot];
                end
            end
            pending.push_back(v);
        endfunction

        function void note_diff(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            end
        endfunction

        function void match_verdict(logic [2:0] st, logic [55:0] word);
            verdict_t oldest;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, status %0d word %h", $time, st, word);
                return;
            end
            oldest = pending.pop_front();
            tally[oldest.status]++;
            note_diff("status", {13'd0, oldest.status}, {13'd0, st});
            note_diff("from_port", oldest.from_port, word[15:0]);
            note_diff("to_port", oldest.to_port, word[31:16]);
            note_diff("payload_len", oldest.payload_len, word[47:32]);
            note_diff("sink_id_out", {13'd0, oldest.sink}, {13'd0, word[50:48]});
        endfunction

        function void flush_missing();
            if (pending.size() != 0) begin
                errors += pending.size();
                $display("%0t: %0d results missing, oldest expected status %0d to_port %0h",
                         $time, pending.size(), pending[0].status, pending[0].to_port);
                pending.delete();
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [IP_W-1:0]       i_cfg_data;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata;
    logic                  i_s_tlast;
    logic [S_TUSER_W-1:0]  i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic [M_TUSER_W-1:0]  o_m_tuser;

    udp_verdicts #(N_SLOTS) book;
    logic [7:0]  dgram [$];
    logic [31:0] cur_lip;
    bit          tx_calm;
    bit          rx_calm;
    int          tx_words;
    longint      cycles;

    udp_receive_checker_core #(
        .TABLE_ENTRIES(N_SLOTS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, book.pending.size());
            $display("testbench failed");
            $finish;
        end
    end

    // result side: random stall before each word, with calm stretches
    initial begin
        int gap;
        i_m_tready = 1'b0;
        rx_calm    = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = rx_calm ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
            book.match_verdict(o_m_tuser, o_m_tdata);
            if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
            @(negedge i_clk);
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input logic [1:0] act, input logic [7:0] d, input logic lst,
                             input logic [31:0] sip, input logic [15:0] prt,
                             input logic [2:0] snk, input bit rush);
        rx_word_t w;
        int       gap;
        w   = '{action: act, data: d, last: lst, src_ip: sip, port: prt, sink: snk};
        gap = (rush || tx_calm) ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'd0, snk, prt, sip, d};
        i_s_tlast  <= lst;
        i_s_tuser  <= act;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        book.take_word(w);
        if (act != ACT_IGNORED) tx_words++;
        @(negedge i_clk);
    endtask

    task automatic send_port_op(input logic [1:0] act, input logic [15:0] prt,
                                input logic [2:0] snk);
        send_word(act, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), $urandom,
                  prt, snk, 1'b0);
    endtask

    task automatic send_noise();
        send_word(ACT_IGNORED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), $urandom,
                  16'($urandom_range(0, 65535)), 3'($urandom_range(0, 7)), 1'b0);
    endtask

    function automatic logic [15:0] pick_port();
        case ($urandom_range(0, 14))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'd7;
            3:       return 16'd53;
            4:       return 16'd80;
            5:       return 16'd123;
            6:       return 16'h8000;
            7:       return 16'h1234;
            8:       return 16'h5555;
            9:       return 16'hAAAA;
            10:      return 16'd4000;
            11:      return 16'h00FF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic random_port_op();
        send_port_op(($urandom_range(0, 4) < 3) ? ACT_OPEN : ACT_CLOSE, pick_port(),
                     3'($urandom_range(0, 7)));
    endtask

    // internet checksum of dgram plus pseudo-header, checksum bytes must be zero
    function automatic logic [15:0] dgram_checksum(input logic [31:0] sip);
        logic [15:0] s;
        int          n;
        n = dgram.size();
        s = '0;
        for (int i = 0; i < n; i += 2)
            s = book.ones_add(s, {dgram[i], (i + 1 < n) ? dgram[i + 1] : 8'h00});
        s = book.ones_add(s, sip[31:16]);
        s = book.ones_add(s, sip[15:0]);
        s = book.ones_add(s, cur_lip[31:16]);
        s = book.ones_add(s, cur_lip[15:0]);
        s = book.ones_add(s, UDP_PROTO);
        s = book.ones_add(s, n[15:0]);
        s = ~s;
        return (s == 16'h0000) ? 16'hFFFF : s;
    endfunction

    // short datagrams take plen as their whole size
    task automatic build_datagram(input logic [15:0] sp, input logic [15:0] dp, input int plen,
                                  input dg_kind_t kind, input logic [31:0] sip);
        int          total;
        logic [15:0] hlen;
        logic [15:0] ck;
        total = (kind == DG_SHORT) ? plen : plen + 8;
        hlen  = total[15:0];
        if (kind == DG_LONG_FIELD)
            hlen = 16'($urandom_range(total + 1, 65535));
        else if (kind != DG_SHORT && $urandom_range(0, 5) == 0)
            hlen = 16'($urandom_range(0, total));
        dgram.delete();
        dgram.push_back(sp[15:8]);
        dgram.push_back(sp[7:0]);
        dgram.push_back(dp[15:8]);
        dgram.push_back(dp[7:0]);
        dgram.push_back(hlen[15:8]);
        dgram.push_back(hlen[7:0]);
        dgram.push_back(8'h00);
        dgram.push_back(8'h00);
        for (int i = 8; i < total; i++) dgram.push_back(8'($urandom_range(0, 255)));
        if (kind == DG_SHORT) begin
            while (dgram.size() > total) void'(dgram.pop_back());
            dgram[dgram.size() - 1] = 8'($urandom_range(0, 255));
        end else begin
            ck = dgram_checksum(sip);
            if (kind == DG_ZERO_CKS) begin
                ck = 16'h0000;
            end else if (kind == DG_BAD_CKS) begin
                ck = dgram_checksum(sip);
                while (ck == 16'h0000 || ck == dgram_checksum(sip))
                    ck = 16'($urandom_range(0, 65535));
            end
            dgram[6] = ck[15:8];
            dgram[7] = ck[7:0];
        end
    endtask

    // edit_at: byte index before which an open of the destination port is slipped in
    task automatic send_dgram(input logic [31:0] sip, input bit rush, input bit noisy,
                              input int edit_at);
        int n;
        n = dgram.size();
        for (int i = 0; i < n; i++) begin
            if (i == edit_at) begin
                send_port_op(ACT_OPEN, {dgram[2], dgram[3]}, 3'd2);
                send_noise();
            end
            if (noisy && $urandom_range(0, 24) == 0) begin
                if ($urandom_range(0, 2) == 0) send_noise();
                else random_port_op();
            end
            send_word(ACT_BYTE, dgram[i], i == n - 1, (i == 0) ? sip : $urandom,
                      16'($urandom_range(0, 65535)), 3'($urandom_range(0, 7)), rush);
        end
    endtask

    task automatic directed_cases();
        send_port_op(ACT_OPEN, 16'hFFFF, 3'd0);
        send_port_op(ACT_OPEN, 16'h0000, 3'd7);
        send_port_op(ACT_OPEN, 16'hFFFF, 3'd5);     // rebind
        send_port_op(ACT_CLOSE, 16'd1234, 3'd0);    // closing an unbound port
        build_datagram(16'hFFFF, 16'hFFFF, 4, DG_GOOD, 32'hFFFF_FFFF);
        send_dgram(32'hFFFF_FFFF, 1'b1, 1'b0, -1);
        build_datagram(16'h0000, 16'h0000, 0, DG_GOOD, 32'h0000_0000);
        send_dgram(32'h0000_0000, 1'b0, 1'b0, -1);
        build_datagram(16'h1234, 16'hFFFF, 3, DG_GOOD, 32'hC0A8_0001);
        send_dgram(32'hC0A8_0001, 1'b0, 1'b0, -1);
        build_datagram(16'h4321, 16'd80, 5, DG_ZERO_CKS, 32'h0A00_0002);
        send_dgram(32'h0A00_0002, 1'b0, 1'b0, -1);
        build_datagram(16'h0001, 16'h0000, 6, DG_BAD_CKS, 32'h0A00_0003);
        send_dgram(32'h0A00_0003, 1'b0, 1'b0, -1);
        build_datagram(16'hABCD, 16'hEF01, 3, DG_SHORT, 32'h0A00_0004);
        send_dgram(32'h0A00_0004, 1'b0, 1'b0, -1);
        build_datagram(16'hFF00, 16'h0000, 1, DG_SHORT, 32'h0A00_0005);
        send_dgram(32'h0A00_0005, 1'b0, 1'b0, -1);
        build_datagram(16'h0ABC, 16'h0000, 2, DG_LONG_FIELD, 32'h0A00_0006);
        send_dgram(32'h0A00_0006, 1'b0, 1'b0, -1);
        send_noise();
        // table edit in the middle of a datagram to the port being opened
        build_datagram(16'h5A5A, 16'd80, 6, DG_GOOD, 32'h7F00_0001);
        send_dgram(32'h7F00_0001, 1'b0, 1'b0, 3);
        send_port_op(ACT_OPEN, 16'd7, 3'd3);
        send_port_op(ACT_OPEN, 16'd53, 3'd4);
        send_port_op(ACT_OPEN, 16'd123, 3'd6);
        send_port_op(ACT_OPEN, 16'h8000, 3'd1);
        send_port_op(ACT_OPEN, 16'h1234, 3'd2);
        send_port_op(ACT_OPEN, 16'h5555, 3'd7);     // no free entry left
        send_port_op(ACT_OPEN, 16'd7, 3'd1);        // rebind while full
        build_datagram(16'h0708, 16'hFFFF, 1, DG_GOOD, 32'h8000_0000);
        send_dgram(32'h8000_0000, 1'b0, 1'b0, -1);
        send_port_op(ACT_CLOSE, 16'hFFFF, 3'd0);
        send_port_op(ACT_CLOSE, 16'h0000, 3'd0);
        send_port_op(ACT_CLOSE, 16'd80, 3'd0);
        send_port_op(ACT_CLOSE, 16'd7, 3'd0);
        send_port_op(ACT_CLOSE, 16'd53, 3'd0);
        send_port_op(ACT_CLOSE, 16'd123, 3'd0);
        send_port_op(ACT_CLOSE, 16'h8000, 3'd0);
        send_port_op(ACT_CLOSE, 16'h1234, 3'd0);
    endtask

    task automatic random_traffic(input int upto);
        int          r;
        int          plen;
        dg_kind_t    kind;
        logic [31:0] sip;
        while (tx_words < upto) begin
            if ($urandom_range(0, 7) == 0) tx_calm = !tx_calm;
            r = $urandom_range(0, 99);
            if (r < 20) begin
                random_port_op();
            end else if (r < 24) begin
                send_noise();
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55)      kind = DG_GOOD;
                else if (r < 65) kind = DG_ZERO_CKS;
                else if (r < 77) kind = DG_BAD_CKS;
                else if (r < 88) kind = DG_LONG_FIELD;
                else             kind = DG_SHORT;
                if (kind == DG_SHORT)
                    plen = $urandom_range(1, 7);
                else if ($urandom_range(0, 15) == 0)
                    plen = $urandom_range(17, 200);
                else
                    plen = $urandom_range(0, 16);
                sip = $urandom;
                build_datagram(16'($urandom_range(0, 65535)), pick_port(), plen, kind, sip);
                send_dgram(sip, 1'b0, 1'b1, -1);
            end
        end
    endtask

    // wait out all verdicts plus the pipeline depth before touching config
    task automatic settle();
        int waited;
        waited = 0;
        i_s_tvalid <= 1'b0;
        while (book.pending.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
        book.flush_missing();
        @(negedge i_clk);
    endtask

    task automatic write_local_ip(input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        book.local_ip = value;
        cur_lip       = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int          base;
        logic [31:0] lip;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tlast   = 1'b0;
        i_s_tuser   = '0;
        tx_calm     = 1'b0;
        tx_words    = 0;
        cur_lip     = '0;
        book        = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // local address left at its reset value for the directed part
        directed_cases();
        settle();

        base = tx_words;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       lip = 32'hFFFF_FFFF;
                2:       lip = 32'h0000_0000;
                default: lip = $urandom;
            endcase
            write_local_ip(lip);
            random_traffic(base + (ph + 1) * 475);
            settle();
        end

        $display("covered %0d datagrams and %0d port table edits under five local addresses",
                 book.datagrams, book.edits);
        $display("verdicts: %0d delivered, %0d length, %0d checksum, %0d unreachable, %0d full",
                 book.tally[ST_DELIVERED], book.tally[ST_LEN_ERR], book.tally[ST_CKS_ERR],
                 book.tally[ST_UNREACH], book.tally[ST_FULL]);
        if (book.errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("%0d mismatches", book.errors);
            $display("testbench failed");
        end
        $finish;
    end

endmodule
